>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/mfe_pkg.sv
`default_nettype none
package mfe_pkg;
    localparam int DefFrameWidth  = 128;
    localparam int DefFrameHeight = 96;
    localparam int ColW  = 7;
    localparam int RowW  = 7;
    localparam int ChgW  = 10;
    localparam int SmW   = 12;
    localparam int GradW = 11;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_GAIN      = 2'd1;
    localparam logic [1:0] REG_WARMUP    = 2'd2;

    typedef struct packed {
        logic [9:0]  threshold;
        logic [11:0] gain;
        logic [7:0]  warmup;
    } cfg_t;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/motion_force_extractor.sv
// channel   | signals                                   | handshake
// pixel in  | red green blue frame_start               | in_valid / in_ready
// result    | center_* intensity push_velocity grad_*  | out_valid / out_ready
// config    | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
// Three pipeline stages plus the output register, one request in flight at a
// time (memory read-modify-write per pixel); a new pixel waits for the last result to be taken.
// After reset a clearing pass zeroes the frame memories; no pixel is taken
// until it ends. Output stall holds input.
`default_nettype none
`include "assert_macros.svh"
module motion_force_extractor
    import mfe_pkg::*;
#(
    parameter int FRAME_WIDTH  = DefFrameWidth,
    parameter int FRAME_HEIGHT = DefFrameHeight
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             center_valid,
    output logic [ColW-1:0]  center_col,
    output logic [RowW-1:0]  center_row,
    output logic [7:0]       intensity,
    output logic             push_velocity,
    output logic signed [GradW-1:0] grad_x,
    output logic signed [GradW-1:0] grad_y
);
    cfg_t cfg;

    mfe_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    mfe_core #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(in_valid), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue), .frame_start(frame_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .center_valid(center_valid), .center_col(center_col), .center_row(center_row),
        .intensity(intensity), .push_velocity(push_velocity),
        .grad_x(grad_x), .grad_y(grad_y)
    );
endmodule
`default_nettype wire

>>> hw/rtl/mfe_regs.sv
`default_nettype none
module mfe_regs
    import mfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);
    logic [9:0]  thr_reg;
    logic [11:0] gain_reg;
    logic [7:0]  warm_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 10'd20;
            gain_reg <= 12'd26;
            warm_reg <= 8'd15;
        end
        else if (wr_en)
        begin
            if (paddr[3:2] == REG_THRESHOLD) thr_reg  <= pwdata[9:0];
            if (paddr[3:2] == REG_GAIN)      gain_reg <= pwdata[11:0];
            if (paddr[3:2] == REG_WARMUP)    warm_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_THRESHOLD: prdata = {22'd0, thr_reg};
            REG_GAIN:      prdata = {20'd0, gain_reg};
            REG_WARMUP:    prdata = {24'd0, warm_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = '{threshold: thr_reg, gain: gain_reg, warmup: warm_reg};
endmodule
`default_nettype wire

>>> hw/rtl/mfe_core.sv
`default_nettype none
`include "assert_macros.svh"
// Stage 0: accept pixel, read frame memories. Stage 1: change, line buffers,
// window, smoothing. Stage 2: compare, intensity, write previous smoothed.
module mfe_core
    import mfe_pkg::*;
#(
    parameter int FRAME_WIDTH  = DefFrameWidth,
    parameter int FRAME_HEIGHT = DefFrameHeight
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cfg_t                   cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              frame_start,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   center_valid,
    output logic [ColW-1:0]        center_col,
    output logic [RowW-1:0]        center_row,
    output logic [7:0]             intensity,
    output logic                   push_velocity,
    output logic signed [GradW-1:0] grad_x,
    output logic signed [GradW-1:0] grad_y
);
    localparam int NPix = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int CW   = $clog2(FRAME_WIDTH);
    localparam int RW   = $clog2(FRAME_HEIGHT);
    localparam int AW   = $clog2(NPix);
    localparam int PW   = $clog2(NPix + 1);

    // memories
    logic [23:0]       frame_mem [NPix];
    logic [SmW-1:0]    smooth_mem [NPix];
    logic [ChgW-1:0]   line0_mem [FRAME_WIDTH];
    logic [ChgW-1:0]   line1_mem [FRAME_WIDTH];

    // clear pass over the frame memories after reset
    logic          clr_busy_reg;
    logic [PW-1:0] clr_cnt_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [7:0]    frames_reg;

    // stage 1
    logic          s1_busy_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic [7:0]    s1_frames_reg;
    logic [23:0]   s1_pix_reg;
    logic [23:0]   prev_rd_reg;
    logic [ChgW-1:0] l0_rd_reg, l1_rd_reg;
    logic [ChgW-1:0] win_reg [9];

    // stage 2
    logic          s2_busy_reg;
    logic          s2_int_reg;
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic          s2_warm_reg;
    logic signed [SmW-1:0] s2_s_reg;
    logic [SmW-1:0] ps_rd_reg;
    logic signed [GradW-1:0] s2_gx_reg, s2_gy_reg;

    logic out_full_reg;

    logic          accept;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [AW-1:0] cur_idx;
    logic [CW-1:0] nxt_col;
    logic [RW-1:0] nxt_row;

    // one pixel in flight at a time; the output register frees at take
    assign in_ready = !clr_busy_reg && !s1_busy_reg && !s2_busy_reg && !out_full_reg;
    assign accept   = in_valid && in_ready;
    assign cur_col  = frame_start ? '0 : col_reg;
    assign cur_row  = frame_start ? '0 : row_reg;
    assign cur_idx  = AW'(cur_row * FRAME_WIDTH + cur_col);

    always_comb
    begin
        nxt_col = cur_col + 1'b1;
        nxt_row = cur_row;
        if (cur_col == CW'(FRAME_WIDTH - 1))
        begin
            nxt_col = '0;
            nxt_row = (cur_row == RW'(FRAME_HEIGHT - 1)) ? '0 : cur_row + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            frames_reg   <= '0;
            s1_busy_reg  <= 1'b0;
            s2_busy_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PW'(NPix - 1)) clr_busy_reg <= 1'b0;
            end
            s1_busy_reg <= accept;
            s2_busy_reg <= s1_busy_reg;
            if (accept)
            begin
                col_reg <= nxt_col;
                row_reg <= nxt_row;
                if (cur_col == '0 && cur_row == '0 && frames_reg != 8'hFF)
                    frames_reg <= frames_reg + 1'b1;
            end
        end
    end

    // stage 0 memory reads, frame memory writes and pipeline capture
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            frame_mem[clr_cnt_reg[AW-1:0]] <= '0;
        else if (accept)
            frame_mem[cur_idx] <= {red, green, blue};
        if (accept)
        begin
            prev_rd_reg   <= frame_mem[cur_idx];
            l0_rd_reg     <= line0_mem[cur_col];
            l1_rd_reg     <= line1_mem[cur_col];
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
            s1_frames_reg <= (cur_col == '0 && cur_row == '0 && frames_reg != 8'hFF)
                             ? frames_reg + 1'b1 : frames_reg;
            s1_pix_reg    <= {red, green, blue};
        end
    end

    // stage 1: change value and window
    logic [ChgW-1:0] chg;
    logic [ChgW-1:0] w_nxt [9];
    logic signed [SmW+8:0] num;
    logic signed [SmW+8:0] sum4;
    logic signed [SmW-1:0] s_val;
    logic [CW-1:0] s1_cc;
    logic [RW-1:0] s1_cr;
    logic [AW-1:0] cidx;

    assign chg = ChgW'(absdiff8(s1_pix_reg[23:16], prev_rd_reg[23:16]))
               + ChgW'(absdiff8(s1_pix_reg[15:8],  prev_rd_reg[15:8]))
               + ChgW'(absdiff8(s1_pix_reg[7:0],   prev_rd_reg[7:0]));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            w_nxt[k*3]     = win_reg[k*3+1];
            w_nxt[k*3 + 1] = win_reg[k*3+2];
        end
        w_nxt[2] = l1_rd_reg;
        w_nxt[5] = l0_rd_reg;
        w_nxt[8] = chg;
    end

    always_comb
    begin
        sum4 = (SmW+9)'(w_nxt[1]) + (SmW+9)'(w_nxt[7]) + (SmW+9)'(w_nxt[3])
             + (SmW+9)'(w_nxt[5]) - ((SmW+9)'(w_nxt[4]) <<< 2);
        num  = ((SmW+9)'(w_nxt[4]) <<< 8) + sum4 * 77;
        // truncate toward zero
        s_val = SmW'((num < 0) ? -((-num) >>> 8) : (num >>> 8));
    end

    assign s1_cc = s1_col_reg - 1'b1;
    assign s1_cr = s1_row_reg - 1'b1;
    assign cidx  = AW'(s1_cr * FRAME_WIDTH + s1_cc);

    always_ff @(posedge clk)
    begin
        if (s1_busy_reg)
        begin
            line1_mem[s1_col_reg] <= l0_rd_reg;
            line0_mem[s1_col_reg] <= chg;
            for (int k = 0; k < 9; k++) win_reg[k] <= w_nxt[k];
            ps_rd_reg   <= smooth_mem[cidx];
            s2_int_reg  <= (s1_col_reg >= CW'(2)) && (s1_row_reg >= RW'(2));
            s2_col_reg  <= s1_cc;
            s2_row_reg  <= s1_cr;
            s2_warm_reg <= s1_frames_reg > cfg.warmup;
            s2_s_reg    <= s_val;
            s2_gx_reg   <= GradW'(w_nxt[3]) - GradW'(w_nxt[5]);
            s2_gy_reg   <= GradW'(w_nxt[1]) - GradW'(w_nxt[7]);
        end
        if (clr_busy_reg)
            smooth_mem[clr_cnt_reg[AW-1:0]] <= '0;
        else if (s2_busy_reg && s2_int_reg)
            smooth_mem[AW'(s2_row_reg * FRAME_WIDTH + s2_col_reg)] <= s2_s_reg;
    end

    // stage 2: result
    logic signed [SmW:0] t_val;
    logic [SmW+11:0]     prod;
    logic [7:0]          inten;
    logic                res_v;

    assign t_val = SmW'(s2_s_reg) - $signed({3'b0, cfg.threshold});
    assign prod  = (t_val > 0) ? (SmW+12)'(t_val[SmW-1:0]) * cfg.gain : '0;
    assign inten = (prod[SmW+11:8] > 255) ? 8'hFF : prod[15:8];
    assign res_v = s2_int_reg && s2_warm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (s2_busy_reg)
            out_full_reg <= 1'b1;
        else if (out_ready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_busy_reg)
        begin
            center_valid  <= res_v;
            center_col    <= res_v ? ColW'(s2_col_reg) : '0;
            center_row    <= res_v ? RowW'(s2_row_reg) : '0;
            intensity     <= res_v ? inten : '0;
            push_velocity <= res_v && (s2_s_reg > $signed(ps_rd_reg));
            grad_x        <= res_v ? s2_gx_reg : '0;
            grad_y        <= res_v ? s2_gy_reg : '0;
        end
    end

    assign out_valid = out_full_reg;

    `ASSERT_NEXT(a_one_in_flight, accept, !in_ready)
    `ASSERT_IMPL(a_no_accept_clear, clr_busy_reg, !accept)
    `ASSERT_NEXT(a_s2_follows, s1_busy_reg, s2_busy_reg)
endmodule
`default_nettype wire

>>> tb/tb_motion_force_extractor.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_motion_force_extractor;
    import mfe_pkg::*;

    localparam int W = DefFrameWidth;
    localparam int H = DefFrameHeight;
    localparam int NPIX = W * H;

    typedef struct packed {
        logic             cvalid;
        logic [ColW-1:0]  col;
        logic [RowW-1:0]  row;
        logic [7:0]       inten;
        logic             push;
        logic [GradW-1:0] gx;
        logic [GradW-1:0] gy;
    } motion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] red = '0, green = '0, blue = '0;
    logic frame_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic center_valid;
    logic [ColW-1:0] center_col;
    logic [RowW-1:0] center_row;
    logic [7:0] intensity;
    logic push_velocity;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;

    motion_force_extractor dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [9:0]  thr_q;
    logic [11:0] gain_q;
    logic [7:0]  warm_q;
    logic [23:0] last_pix [NPIX];
    logic signed [SmW-1:0] last_smooth [NPIX];
    logic [ChgW-1:0] line_up [W];
    logic [ChgW-1:0] line_mid [W];
    logic [ChgW-1:0] win [9];
    int col_q, row_q, frames_q;

    motion_t expected_motion [$];
    int errors = 0;
    int snd_idle = 0;   // percent
    int rcv_stall = 0;  // percent
    bit hold_off = 1'b0;

    function automatic int adiff(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic fs);
        int idx, d, c, up, dn, lf, rt, num, s, t, iv, cidx;
        motion_t m;
        m = '0;
        if (fs)
        begin
            col_q = 0;
            row_q = 0;
        end
        if (col_q == 0 && row_q == 0 && frames_q < 255) frames_q++;
        idx = row_q * W + col_q;
        d = adiff(r, last_pix[idx][23:16]) + adiff(g, last_pix[idx][15:8])
            + adiff(b, last_pix[idx][7:0]);
        last_pix[idx] = {r, g, b};
        for (int k = 0; k < 3; k++)
        begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = line_up[col_q];
        win[5] = line_mid[col_q];
        win[8] = d[ChgW-1:0];
        line_up[col_q] = line_mid[col_q];
        line_mid[col_q] = d[ChgW-1:0];
        if (col_q >= 2 && row_q >= 2)
        begin
            cidx = (row_q - 1) * W + col_q - 1;
            c = win[4]; up = win[1]; dn = win[7]; lf = win[3]; rt = win[5];
            num = 256 * c + 77 * (up + dn + lf + rt - 4 * c);
            s = num / 256;
            m.push = s > int'(last_smooth[cidx]);
            last_smooth[cidx] = s[SmW-1:0];
            if (frames_q > warm_q)
            begin
                t = s - int'(thr_q);
                iv = 0;
                if (t > 0)
                begin
                    iv = (t * int'(gain_q)) >>> 8;
                    if (iv > 255) iv = 255;
                end
                m.cvalid = 1'b1;
                m.col = ColW'(col_q - 1);
                m.row = RowW'(row_q - 1);
                m.inten = iv[7:0];
                m.gx = GradW'(lf - rt);
                m.gy = GradW'(up - dn);
            end
            else m.push = 1'b0;
        end
        expected_motion.push_back(m);
        col_q++;
        if (col_q >= W)
        begin
            col_q = 0;
            row_q++;
            if (row_q >= H) row_q = 0;
        end
    endtask

    task automatic write_reg(input logic [1:0] regidx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {regidx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (regidx)
            REG_THRESHOLD: thr_q = val[9:0];
            REG_GAIN:      gain_q = val[11:0];
            default:       warm_q = val[7:0];
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fs);
        while (snd_idle > 0 && $urandom_range(99) < snd_idle) @(negedge clk);
        in_valid = 1'b1;
        red = r; green = g; blue = b; frame_start = fs;
        do @(posedge clk); while (!in_ready);
        predict_pixel(r, g, b, fs);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= !hold_off && !(rcv_stall > 0 && $urandom_range(99) < rcv_stall);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            motion_t m;
            if (expected_motion.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                m = expected_motion.pop_front();
                if (center_valid !== m.cvalid)
                begin
                    $error("center_valid exp %0d got %0d", m.cvalid, center_valid);
                    errors++;
                end
                if (center_col !== m.col)
                begin
                    $error("center_col exp %0d got %0d", m.col, center_col);
                    errors++;
                end
                if (center_row !== m.row)
                begin
                    $error("center_row exp %0d got %0d", m.row, center_row);
                    errors++;
                end
                if (intensity !== m.inten)
                begin
                    $error("intensity exp %0d got %0d", m.inten, intensity);
                    errors++;
                end
                if (push_velocity !== m.push)
                begin
                    $error("push_velocity exp %0d got %0d", m.push, push_velocity);
                    errors++;
                end
                if (grad_x !== m.gx)
                begin
                    $error("grad_x exp %0d got %0d", $signed(m.gx), grad_x);
                    errors++;
                end
                if (grad_y !== m.gy)
                begin
                    $error("grad_y exp %0d got %0d", $signed(m.gy), grad_y);
                    errors++;
                end
            end
        end
    end

    task automatic drain;
        while (expected_motion.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // npix pixels of a frame; mode 0 random, 1 all max, 2 all zero, 3 sparse red/green over random blue
    task automatic send_frame(input int npix, input int mode, input bit mark);
        logic [7:0] r, g, b;
        for (int i = 0; i < npix; i++)
        begin
            case (mode)
                1: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
                2: begin r = 8'h00; g = 8'h00; b = 8'h00; end
                3: begin
                    r = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
                    g = r; b = 8'($urandom);
                end
                default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
            endcase
            send_pixel(r, g, b, mark && i == 0);
        end
    endtask

    task automatic test_directed;
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_GAIN, 4095);
        write_reg(REG_WARMUP, 0);
        // start of the first row, extremes; frame_start mid-row resyncs
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        for (int i = 0; i < 8; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h01, 1'b1);
        for (int i = 0; i < 8; i++) send_pixel(8'($urandom), 8'h80, 8'h7F, 1'b0);
        drain();
    endtask

    // partial frames of two rows plus 20 pixels exercise interior centres, push and the gradients
    task automatic test_full_frames(input int nframes);
        for (int f = 0; f < nframes; f++)
            send_frame(2 * W + 20, f % 4, 1'b1);
        drain();
    endtask

    task automatic test_warmup_and_gain;
        write_reg(REG_THRESHOLD, 1023);
        write_reg(REG_GAIN, 0);
        write_reg(REG_WARMUP, 255);
        send_frame(2 * W + 8, 0, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, $urandom_range(60));
        write_reg(REG_GAIN, $urandom_range(4095));
        write_reg(REG_WARMUP, 0);
        snd_idle = 85;
        send_frame(2 * W + 20, 0, 1'b1);
        drain();
        snd_idle = 0;
    endtask

    task automatic test_random(input int n);
        int phase;
        phase = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % (n / 4) == 0)
            begin
                phase = (phase + 1) % 5;
                snd_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 85 : 31) : 0;
                rcv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 85 : 31) : 0;
            end
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(199) == 0);
        end
        snd_idle = 0;
        rcv_stall = 0;
        drain();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        join
        drain();
    endtask

    initial
    begin
        thr_q = 20; gain_q = 26; warm_q = 15;
        for (int i = 0; i < NPIX; i++)
        begin
            last_pix[i] = '0;
            last_smooth[i] = '0;
        end
        for (int i = 0; i < W; i++)
        begin
            line_up[i] = '0;
            line_mid[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_q = 0; row_q = 0; frames_q = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_frames(3);
        test_warmup_and_gain();
        test_random(360);
        test_backpressure();
        write_reg(REG_THRESHOLD, 20);
        write_reg(REG_GAIN, 26);
        write_reg(REG_WARMUP, 15);
        test_random(100);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
